// ===== sv/kvtl_pkg.sv =====
// ----------------------------------------------------------------------------
// kvtl_pkg: shared types and constants for the linear key-value table
// Capacity, field widths, operation and status codes, cell control bundle.
// ----------------------------------------------------------------------------
package kvtl_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_W    = 16;
  localparam int VALUE_W  = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;

  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [VALUE_W-1:0]  value_t;
  typedef logic [CNT_W-1:0]    count_t;
  typedef logic [FUNC_W-1:0]   func_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam func_t FUNC_LOOKUP = 2'd0;
  localparam func_t FUNC_INSERT = 2'd1;
  localparam func_t FUNC_DELETE = 2'd2;

  localparam status_t ST_DONE    = 2'd0;
  localparam status_t ST_PRESENT = 2'd1;
  localparam status_t ST_ABSENT  = 2'd2;
  localparam status_t ST_FULL    = 2'd3;

  // broadcast from the controller to every cell
  typedef struct packed {
    key_t   key;
    value_t value;
    logic   del_en;   // delete hit: cells at or above the hit take from neighbor
    logic   ins_en;   // insert of a new key: tail cell loads
  } cell_ctl_t;

endpackage

// ===== sv/kvtl_cell.sv =====
// ----------------------------------------------------------------------------
// kvtl_cell: one entry of the key-value table
// Holds a key and value, compares against the broadcast key, passes the hit
// flag up the chain and takes its neighbor's entry when a delete closes a gap.
// ----------------------------------------------------------------------------
module kvtl_cell (
  input  logic               clk,
  input  kvtl_pkg::cell_ctl_t ctl,
  input  logic               valid,
  input  logic               tail,
  input  logic               hit_in,
  input  kvtl_pkg::key_t     nxt_key,
  input  kvtl_pkg::value_t   nxt_value,
  output logic               hit,
  output logic               hit_out,
  output kvtl_pkg::key_t     key_q,
  output kvtl_pkg::value_t   value_q,
  output kvtl_pkg::value_t   rd_value
);

  kvtl_pkg::key_t   key_r;
  kvtl_pkg::value_t value_r;
  logic             seen;

  assign hit      = valid && (key_r == ctl.key);
  assign seen     = hit_in | hit;
  assign hit_out  = seen;
  assign key_q    = key_r;
  assign value_q  = value_r;
  assign rd_value = hit ? value_r : '0;

  always_ff @(posedge clk) begin
    if (ctl.del_en && seen) begin
      key_r   <= nxt_key;
      value_r <= nxt_value;
    end else if (ctl.ins_en && tail) begin
      key_r   <= ctl.key;
      value_r <= ctl.value;
    end
  end

endmodule

// ===== sv/key_value_table_linear_core.sv =====
// ----------------------------------------------------------------------------
// key_value_table_linear_core: packed key-value table, lookup/insert/delete
// Row of entry cells with a shared compare key; deletes shift entries down.
// ----------------------------------------------------------------------------
//  channel  | ports                      | payload
//  ---------+----------------------------+-------------------------------------
//  in       | in_tvalid/in_tready        | func, key, value
//  out      | out_tvalid/out_tready      | status, read_value, entry_count,
//           |                            | is_empty, is_full
//  cfg      | cfg_valid/cfg_ready        | miss_value (always ready)
//
//  An item is taken in the accept state, then handled in the execute state, in
//  which every cell compares its key, the hit ripples up the cell row and the
//  table is updated. The execute state repeats while the result register is
//  full and not being taken. Input is taken while a result waits.
//  Reset clears the entry count, miss value and control; cell contents are
//  not cleared, cells above the count are never read.
// ----------------------------------------------------------------------------
module key_value_table_linear_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // func[1:0], key[17:2], value[33:18], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // status[1:0], read_value[17:2],
                                  // entry_count[22:18], is_empty[23],
                                  // is_full[24], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int N = kvtl_pkg::CAPACITY;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                state_r, state_nxt;
  kvtl_pkg::count_t    count_r, count_nxt;
  kvtl_pkg::value_t    miss_r;
  kvtl_pkg::func_t     func_r;
  kvtl_pkg::key_t      key_r;
  kvtl_pkg::value_t    value_r;

  logic                out_valid_r;
  kvtl_pkg::status_t   status_r, status_nxt;
  kvtl_pkg::value_t    rdv_r, rdv_nxt;
  kvtl_pkg::count_t    ocnt_r;

  kvtl_pkg::cell_ctl_t ctl;
  logic [N-1:0]        valid_v, tail_v, hit_v, chain_v;
  kvtl_pkg::key_t      key_a   [N];
  kvtl_pkg::value_t    val_a   [N];
  kvtl_pkg::value_t    rdval_a [N];
  kvtl_pkg::key_t      nkey_a  [N];
  kvtl_pkg::value_t    nval_a  [N];
  kvtl_pkg::value_t    hit_value;
  logic                any_hit;
  logic                fire;
  logic                in_xfer;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign fire      = (state_r == S_EXEC) && (!out_valid_r || out_tready);
  assign cfg_ready = 1'b1;

  // ---- cell row
  genvar gi;
  generate
    for (gi = 0; gi < N; gi++) begin : g_cell
      logic hit_in;
      assign valid_v[gi] = kvtl_pkg::count_t'(gi) < count_r;
      assign tail_v[gi]  = count_r == kvtl_pkg::count_t'(gi);
      if (gi == 0) begin : g_first
        assign hit_in = 1'b0;
      end else begin : g_rest
        assign hit_in = chain_v[gi-1];
      end
      if (gi == N - 1) begin : g_last
        assign nkey_a[gi] = key_a[gi];
        assign nval_a[gi] = '0;
      end else begin : g_mid
        assign nkey_a[gi] = key_a[gi+1];
        assign nval_a[gi] = val_a[gi+1];
      end
      kvtl_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .valid    (valid_v[gi]),
        .tail     (tail_v[gi]),
        .hit_in   (hit_in),
        .nxt_key  (nkey_a[gi]),
        .nxt_value(nval_a[gi]),
        .hit      (hit_v[gi]),
        .hit_out  (chain_v[gi]),
        .key_q    (key_a[gi]),
        .value_q  (val_a[gi]),
        .rd_value (rdval_a[gi])
      );
    end
  endgenerate

  assign any_hit = chain_v[N-1];

  // at most one cell hits, so an OR merges the read data
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < N; i++) begin
      hit_value = hit_value | rdval_a[i];
    end
  end

  // ---- operation decode
  always_comb begin
    ctl.key    = key_r;
    ctl.value  = value_r;
    ctl.del_en = 1'b0;
    ctl.ins_en = 1'b0;
    status_nxt = kvtl_pkg::ST_DONE;
    rdv_nxt    = '0;
    count_nxt  = count_r;
    case (func_r)
      kvtl_pkg::FUNC_LOOKUP: begin
        if (any_hit) begin
          rdv_nxt = hit_value;
        end else begin
          rdv_nxt    = miss_r;
          status_nxt = kvtl_pkg::ST_ABSENT;
        end
      end
      kvtl_pkg::FUNC_INSERT: begin
        if (any_hit) begin
          status_nxt = kvtl_pkg::ST_PRESENT;
        end else if (count_r == kvtl_pkg::count_t'(N)) begin
          status_nxt = kvtl_pkg::ST_FULL;
        end else begin
          ctl.ins_en = fire;
          count_nxt  = count_r + 1'b1;
        end
      end
      kvtl_pkg::FUNC_DELETE: begin
        if (any_hit) begin
          ctl.del_en = fire;
          count_nxt  = count_r - 1'b1;
        end else begin
          status_nxt = kvtl_pkg::ST_ABSENT;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_xfer) state_nxt = S_EXEC;
      S_EXEC:  if (fire)    state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      miss_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        miss_r <= cfg_data;
      end
      if (fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      func_r  <= in_tdata[1:0];
      key_r   <= in_tdata[17:2];
      value_r <= in_tdata[33:18];
    end
    if (fire) begin
      status_r <= status_nxt;
      rdv_r    <= rdv_nxt;
      ocnt_r   <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0,
                       ocnt_r == kvtl_pkg::count_t'(N),
                       ocnt_r == '0,
                       ocnt_r, rdv_r, status_r};

  // ---- checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= kvtl_pkg::count_t'(N))
    else $error("entry count above capacity");

  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_v))
    else $error("key held in more than one cell");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(count_r))
    else $error("entry count changed without an executed operation");

  a_exec_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_EXEC) && !in_tready)
    else $error("accepted item not executed");

endmodule

// ===== bench/tb_key_value_table_linear_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_key_value_table_linear_core: self-checking bench for the linear kv table
// Drives lookup/insert/delete items through the in stream and predicts each
// result with a local copy of the table. Every out transfer is checked field
// by field. Covers fill to capacity, shift on delete and miss value writes,
// then random traffic with stalls on both sides.
// ----------------------------------------------------------------------------
module tb_key_value_table_linear_core;

  localparam kvtl_pkg::func_t FUNC_UNUSED = 2'd3;
  localparam int              CYCLE_LIMIT = 400000;
  localparam int              POOL_SIZE   = 24;

  typedef struct {
    kvtl_pkg::status_t status;
    kvtl_pkg::value_t  read_value;
    kvtl_pkg::count_t  entry_count;
    logic              is_empty;
    logic              is_full;
  } kv_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // func[1:0], key[17:2], value[33:18], zero pad
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // status[1:0], read_value[17:2], entry_count[22:18],
                           // is_empty[23], is_full[24], zero pad
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  // local copy of the table
  kvtl_pkg::key_t   tbl_keys [kvtl_pkg::CAPACITY];
  kvtl_pkg::value_t tbl_vals [kvtl_pkg::CAPACITY];
  int               tbl_count;
  kvtl_pkg::value_t tbl_miss;

  kv_result_t     pending_results[$];
  kvtl_pkg::key_t key_pool[POOL_SIZE];

  int error_count;
  int cycle_count;
  int rx_hold;
  int rx_gap;
  bit tx_idle_on;
  bit rx_idle_on;

  key_value_table_linear_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic kv_result_t table_apply(kvtl_pkg::func_t f, kvtl_pkg::key_t k,
                                             kvtl_pkg::value_t v);
    kv_result_t r;
    int hit;
    hit = -1;
    for (int i = 0; i < tbl_count; i++) begin
      if (hit < 0 && tbl_keys[i] == k) hit = i;
    end
    r.status     = kvtl_pkg::ST_DONE;
    r.read_value = '0;
    case (f)
      kvtl_pkg::FUNC_LOOKUP: begin
        if (hit >= 0) r.read_value = tbl_vals[hit];
        else begin
          r.read_value = tbl_miss;
          r.status     = kvtl_pkg::ST_ABSENT;
        end
      end
      kvtl_pkg::FUNC_INSERT: begin
        if (hit >= 0) r.status = kvtl_pkg::ST_PRESENT;
        else if (tbl_count >= kvtl_pkg::CAPACITY) r.status = kvtl_pkg::ST_FULL;
        else begin
          tbl_keys[tbl_count] = k;
          tbl_vals[tbl_count] = v;
          tbl_count++;
        end
      end
      kvtl_pkg::FUNC_DELETE: begin
        if (hit >= 0) begin
          // close the gap; only held entries above the hit move
          for (int i = hit; i + 1 < tbl_count; i++) begin
            tbl_keys[i] = tbl_keys[i+1];
            tbl_vals[i] = tbl_vals[i+1];
          end
          tbl_count--;
        end else r.status = kvtl_pkg::ST_ABSENT;
      end
      default: ;
    endcase
    r.entry_count = kvtl_pkg::count_t'(tbl_count);
    r.is_empty    = (tbl_count == 0);
    r.is_full     = (tbl_count == kvtl_pkg::CAPACITY);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] want, logic [15:0] got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    error_count++;
  endtask

  // one input transfer; the result is predicted when the item is taken
  task automatic send_op(kvtl_pkg::func_t f, kvtl_pkg::key_t k, kvtl_pkg::value_t v);
    int gap;
    gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, v, k, f};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(table_apply(f, k, v));
  endtask

  task automatic wait_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_miss_value(kvtl_pkg::value_t mv);
    wait_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= mv;
    do @(posedge clk); while (!cfg_ready);
    tbl_miss = mv;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic kvtl_pkg::key_t fill_key(int i);
    if (i == 0) return 16'h0000;
    if (i == kvtl_pkg::CAPACITY - 1) return 16'hFFFF;
    return kvtl_pkg::key_t'((i << 12) ^ 16'h0A5 ^ i);
  endfunction

  task automatic test_empty_table();
    send_op(kvtl_pkg::FUNC_LOOKUP, 16'h0000, 16'hFFFF);   // miss with reset miss value
    send_op(kvtl_pkg::FUNC_DELETE, 16'hFFFF, 16'h0000);
    send_op(FUNC_UNUSED, 16'h5A5A, 16'hA5A5);
  endtask

  task automatic test_fill_to_capacity();
    for (int i = 0; i < kvtl_pkg::CAPACITY; i++)
      send_op(kvtl_pkg::FUNC_INSERT, fill_key(i),
              kvtl_pkg::value_t'(16'hFFFF - i * 16'h1111));
    send_op(kvtl_pkg::FUNC_INSERT, 16'h0000, 16'h1234);   // present while full
    send_op(kvtl_pkg::FUNC_INSERT, 16'h1234, 16'h4321);   // new key, table full
  endtask

  task automatic test_delete_shift();
    set_miss_value(16'hFFFF);
    send_op(kvtl_pkg::FUNC_DELETE, fill_key(5), 16'h0);
    send_op(kvtl_pkg::FUNC_LOOKUP, fill_key(6), 16'h0);
    send_op(kvtl_pkg::FUNC_LOOKUP, fill_key(kvtl_pkg::CAPACITY - 1), 16'h0);
    send_op(kvtl_pkg::FUNC_DELETE, fill_key(kvtl_pkg::CAPACITY - 1), 16'h0);
    send_op(kvtl_pkg::FUNC_DELETE, fill_key(0), 16'h0);
    send_op(kvtl_pkg::FUNC_LOOKUP, fill_key(5), 16'h0);
  endtask

  // receiver holds off while the sender keeps offering, input must stall
  task automatic test_output_backpressure();
    wait_results();
    tx_idle_on = 1'b0;
    rx_hold    = 80;
    for (int i = 0; i < 30; i++)
      send_op(kvtl_pkg::func_t'($urandom_range(0, 2)), key_pool[$urandom_range(0, 7)],
              kvtl_pkg::value_t'($urandom));
    wait_results();
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_ops(int n_items, int ins_pct, int del_pct);
    int               r;
    kvtl_pkg::func_t  f;
    kvtl_pkg::key_t   k;
    kvtl_pkg::value_t v;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < ins_pct) f = kvtl_pkg::FUNC_INSERT;
      else if (r < ins_pct + del_pct) f = kvtl_pkg::FUNC_DELETE;
      else if (r < 97) f = kvtl_pkg::FUNC_LOOKUP;
      else f = FUNC_UNUSED;
      k = ($urandom_range(0, 9) == 0) ? kvtl_pkg::key_t'($urandom)
                                       : key_pool[$urandom_range(0, POOL_SIZE - 1)];
      case ($urandom_range(0, 7))
        0:       v = 16'h0000;
        1:       v = 16'hFFFF;
        default: v = kvtl_pkg::value_t'($urandom);
      endcase
      send_op(f, k, v);
    end
  endtask

  // receiver: random stall bursts, plus a long hold when asked
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_tready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
      rx_gap = $urandom_range(1, 12) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    kv_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 16'h0, out_tdata[15:0]);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[1:0] !== want.status)
          report_mismatch("status", want.status, out_tdata[1:0]);
        if (out_tdata[17:2] !== want.read_value)
          report_mismatch("read_value", want.read_value, out_tdata[17:2]);
        if (out_tdata[22:18] !== want.entry_count)
          report_mismatch("entry_count", want.entry_count, out_tdata[22:18]);
        if (out_tdata[23] !== want.is_empty)
          report_mismatch("is_empty", want.is_empty, out_tdata[23]);
        if (out_tdata[24] !== want.is_full)
          report_mismatch("is_full", want.is_full, out_tdata[24]);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    error_count = 0;
    cycle_count = 0;
    rx_hold     = 0;
    rx_gap      = 0;
    tx_idle_on  = 1'b1;
    rx_idle_on  = 1'b1;
    tbl_count   = 0;
    tbl_miss    = '0;
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = kvtl_pkg::key_t'($urandom);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_fill_to_capacity();
    test_delete_shift();
    test_output_backpressure();
    test_random_ops(700, 45, 25);
    set_miss_value(kvtl_pkg::value_t'($urandom));
    test_random_ops(700, 25, 40);
    set_miss_value(16'h0000);
    wait_results();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_ops(400, 40, 30);
    wait_results();
    repeat (10) @(posedge clk);

    if (error_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
